[rtl/bfrd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfrd_pkg: shared types and constants of the brace fold-region detector
// Item kinds, brace codes, the stack operation struct and the result record.
// ----------------------------------------------------------------------------
package bfrd_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int LINE_BITS_DEF   = 16;

    localparam int KIND_BITS  = 2;
    localparam int CHAR_BITS  = 8;
    localparam int SPAN_BITS  = 4;
    localparam int REGION_W   = 16;
    localparam int DEPTH_W    = 7;

    localparam logic [SPAN_BITS-1:0] MIN_SPAN_RST = 4'd1;

    localparam logic [CHAR_BITS-1:0] OPEN_BRACE  = 8'h7B;
    localparam logic [CHAR_BITS-1:0] CLOSE_BRACE = 8'h7D;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_CHAR = 2'd0,
        KIND_LINE = 2'd1,
        KIND_DOC  = 2'd2
    } t_item_kind;

    // Operation broadcast to every cell of the stack chain.
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_op;

    // One result record as it leaves the block.
    typedef struct packed {
        logic                region_valid;
        logic [REGION_W-1:0] region_start;
        logic [REGION_W-1:0] region_end;
        logic [DEPTH_W-1:0]  open_depth;
        logic                overflowed;
    } t_result;

endpackage
`default_nettype wire

[rtl/brace_fold_region_detector.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// brace_fold_region_detector: brace-matching fold-region finder
// Counts lines, keeps open-brace lines on a stack and reports fold regions.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock cycle and gives exactly one
// result transaction for each, in the cycle after its input when the output
// is free. Throughput is one item per cycle: the stack is a chain of cells
// that all shift together on a push or pop, and the span test is one subtract
// and compare on the top cell, so each item's effect on the state is complete
// before the next one is taken. A two-entry output buffer keeps the
// input ready for one further transaction while a result waits; beyond that
// the input stalls until results are taken. A start-of-document item clears
// the stack depth, the line counter and the overflow flag; stack contents are
// never cleared because only entries below the depth are ever read. The
// minimum span register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module brace_fold_region_detector #(
    parameter int STACK_DEPTH = bfrd_pkg::STACK_DEPTH_DEF,
    parameter int LINE_BITS   = bfrd_pkg::LINE_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration: minimum span
    input  wire         i_cfg_wr_en,
    input  wire  [3:0]  i_cfg_wr_data,
    // Input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire  [1:0]  s_axis_tuser,   // [1:0] item_kind
    // Result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] region_start, [31:16] region_end,
                                        // [38:32] open_depth, [39] overflowed
    output logic [0:0]  m_axis_tuser    // [0] region_valid
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0]     CNT_FULL = CNT_W'(STACK_DEPTH);
    localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

    // State registers
    logic [CNT_W-1:0]              r_count;
    logic [CNT_W-1:0]              n_count;
    logic [LINE_BITS-1:0]          r_line;
    logic [LINE_BITS-1:0]          n_line;
    logic                          r_ovf;
    logic                          n_ovf;
    logic [bfrd_pkg::SPAN_BITS-1:0] r_min_span;

    logic                 w_accept;
    bfrd_pkg::t_item_kind w_kind;
    logic                 w_is_open;
    logic                 w_is_close;
    logic                 w_full;
    logic                 w_empty;
    bfrd_pkg::t_stack_op  w_op;
    logic [LINE_BITS-1:0] w_top;
    logic [LINE_BITS-1:0] w_diff;
    logic                 w_hit;
    logic [31:0]          w_start_ext;
    logic [31:0]          w_end_ext;
    logic [31:0]          w_depth_ext;
    bfrd_pkg::t_result    w_result;
    bfrd_pkg::t_result    w_out;

    assign w_kind     = bfrd_pkg::t_item_kind'(s_axis_tuser);
    assign w_is_open  = (s_axis_tdata == bfrd_pkg::OPEN_BRACE);
    assign w_is_close = (s_axis_tdata == bfrd_pkg::CLOSE_BRACE);
    assign w_full     = (r_count == CNT_FULL);
    assign w_empty    = (r_count == '0);

    // Configuration register; the user must write it only while the block is idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_span <= bfrd_pkg::MIN_SPAN_RST;
        end else if (i_cfg_wr_en) begin
            r_min_span <= i_cfg_wr_data;
        end
    end

    // Next-state decode for the counters, flag and stack operation.
    always_comb begin
        n_count    = r_count;
        n_line     = r_line;
        n_ovf      = r_ovf;
        w_op.push  = 1'b0;
        w_op.pop   = 1'b0;
        if (w_accept) begin
            case (w_kind)
                bfrd_pkg::KIND_DOC: begin
                    n_count = '0;
                    n_line  = '0;
                    n_ovf   = 1'b0;
                end
                bfrd_pkg::KIND_LINE: begin
                    if (r_line != LINE_MAX) begin
                        n_line = r_line + 1'b1;
                    end
                end
                bfrd_pkg::KIND_CHAR: begin
                    if (w_is_open) begin
                        if (w_full) begin
                            n_ovf = 1'b1;
                        end else begin
                            w_op.push = 1'b1;
                            n_count   = r_count + 1'b1;
                        end
                    end else if (w_is_close && !w_empty) begin
                        w_op.pop = 1'b1;
                        n_count  = r_count - 1'b1;
                    end
                end
                default: begin
                    // Unused kind: state is left alone.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_line  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_line  <= n_line;
            r_ovf   <= n_ovf;
        end
    end

    bfrd_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .LINE_BITS   (LINE_BITS)
    ) u_stack (
        .i_clk       (i_clk),
        .i_op        (w_op),
        .i_push_line (r_line),
        .o_top_line  (w_top)
    );

    // The top cell holds the matching open line at the moment of a pop.
    assign w_diff = r_line - w_top;
    assign w_hit  = w_op.pop && (r_line >= w_top)
                    && (w_diff >= LINE_BITS'(r_min_span));

    // Results are masked to the fixed output widths.
    assign w_start_ext = 32'(w_top);
    assign w_end_ext   = 32'(r_line);
    assign w_depth_ext = 32'(n_count);

    always_comb begin
        w_result.region_valid = w_hit;
        w_result.region_start = w_hit ? w_start_ext[bfrd_pkg::REGION_W-1:0] : '0;
        w_result.region_end   = w_hit ? w_end_ext[bfrd_pkg::REGION_W-1:0] : '0;
        w_result.open_depth   = w_depth_ext[bfrd_pkg::DEPTH_W-1:0];
        w_result.overflowed   = n_ovf;
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    bfrd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = {w_out.overflowed, w_out.open_depth,
                           w_out.region_end, w_out.region_start};
    assign m_axis_tuser = w_out.region_valid;

    // The stack depth never exceeds the number of cells.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("stack depth beyond number of cells");

    // A start-of-document transaction leaves depth, line and flag cleared.
    a_doc_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_kind == bfrd_pkg::KIND_DOC)
        |=> (r_count == '0 && r_line == '0 && !r_ovf))
        else $error("start of document did not clear state");

    // The overflow flag rises only on an open brace meeting a full stack.
    a_ovf_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> $past(w_accept && w_kind == bfrd_pkg::KIND_CHAR
                               && w_is_open && w_full))
        else $error("overflow flag set without a dropped open brace");

    // The line counter only steps by one or returns to zero.
    a_line_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_line) |-> (r_line == '0
                              || r_line == LINE_BITS'($past(r_line) + 1'b1)))
        else $error("line counter jumped");

    // A reported region never ends before it starts.
    a_region_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> (w_top <= r_line && !w_empty))
        else $error("region reported with bad ordering or empty stack");

endmodule
`default_nettype wire

[rtl/bfrd_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfrd_cell: one entry of the shifting brace stack
// Takes the entry above on a push and the entry below on a pop.
// ----------------------------------------------------------------------------
module bfrd_cell #(
    parameter int LINE_BITS = bfrd_pkg::LINE_BITS_DEF
) (
    input  wire                       i_clk,
    input  wire bfrd_pkg::t_stack_op  i_op,
    input  wire [LINE_BITS-1:0]       i_from_above,
    input  wire [LINE_BITS-1:0]       i_from_below,
    output logic [LINE_BITS-1:0]      o_entry
);

    logic [LINE_BITS-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_entry <= i_from_above;
        end else if (i_op.pop) begin
            r_entry <= i_from_below;
        end
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

[rtl/bfrd_stack.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfrd_stack: chain of cells forming the open-brace line stack
// Cell 0 is the top of stack; pushes shift the chain down, pops shift it up.
// ----------------------------------------------------------------------------
module bfrd_stack #(
    parameter int STACK_DEPTH = bfrd_pkg::STACK_DEPTH_DEF,
    parameter int LINE_BITS   = bfrd_pkg::LINE_BITS_DEF
) (
    input  wire                       i_clk,
    input  wire bfrd_pkg::t_stack_op  i_op,
    input  wire [LINE_BITS-1:0]       i_push_line,
    output logic [LINE_BITS-1:0]      o_top_line
);

    logic [LINE_BITS-1:0] w_entry [STACK_DEPTH];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [LINE_BITS-1:0] w_above;
        logic [LINE_BITS-1:0] w_below;

        if (g == 0) begin : g_top
            assign w_above = i_push_line;
        end else begin : g_mid
            assign w_above = w_entry[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_bottom
            assign w_below = '0;
        end else begin : g_upper
            assign w_below = w_entry[g+1];
        end

        bfrd_cell #(
            .LINE_BITS (LINE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_op         (i_op),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_entry      (w_entry[g])
        );
    end

    assign o_top_line = w_entry[0];

endmodule
`default_nettype wire

[rtl/bfrd_out_buf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfrd_out_buf: output register with skid stage
// Holds up to two results so the input side keeps flowing under back-pressure.
// ----------------------------------------------------------------------------
module bfrd_out_buf (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire bfrd_pkg::t_result  i_data,
    output logic                    o_valid,
    input  wire                     i_ready,
    output bfrd_pkg::t_result       o_data
);

    logic              r_out_v;
    logic              r_skid_v;
    bfrd_pkg::t_result r_out;
    bfrd_pkg::t_result r_skid;
    logic              w_load;
    logic              w_take;

    assign o_ready = !r_skid_v;
    assign w_load  = i_valid && !r_skid_v;
    assign w_take  = r_out_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_load) begin
            if (!r_out_v || w_take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            if (r_skid_v) begin
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (!r_out_v || w_take) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end else if (w_take && r_skid_v) begin
            r_out <= r_skid;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule
`default_nettype wire
